>>> src/mpts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpts_pkg: shared types and constants of the picture timestamper
// Timestamp width, header codes, the frame rate table and the front-to-back
// event word.
// ----------------------------------------------------------------------------
package mpts_pkg;

  localparam int TsBits = 33;
  localparam int QDepth = 4;
  localparam int QPtrBits = $clog2(QDepth);

  typedef enum logic [1:0] {
    HDR_NONE = 2'd0,
    HDR_SEQ  = 2'd1,
    HDR_PIC  = 2'd2
  } hdr_mode_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_SEQ  = 2'd1,
    EV_PIC  = 2'd2
  } ev_kind_t;

  localparam logic [2:0] PicI = 3'd1;
  localparam logic [2:0] PicB = 3'd3;
  localparam logic [2:0] PicD = 3'd4;

  // One word from the front (byte parser) to the back (timestamp engine).
  typedef struct packed {
    ev_kind_t          kind;
    logic              first;
    logic              last;
    logic [TsBits-1:0] pts;
    logic              pts_valid;
    logic [TsBits-1:0] dts;
    logic              dts_valid;
    logic [31:0]       capture;
    logic [2:0]        ptype;
  } ev_t;

  function automatic logic [11:0] rate_ticks(input logic [3:0] rc);
    logic [11:0] r;
    case (rc)
      4'd1:    r = 12'd3753;
      4'd2:    r = 12'd3750;
      4'd3:    r = 12'd3600;
      4'd4:    r = 12'd3003;
      4'd5:    r = 12'd3000;
      4'd6:    r = 12'd1800;
      4'd7:    r = 12'd1501;
      4'd8:    r = 12'd1500;
      default: r = 12'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/mpts_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpts_front: start code search and header capture
// Scans bytes for start codes within a packet and emits one event word per
// byte taken, carrying packet timestamps and marking a completed header.
// ----------------------------------------------------------------------------
module mpts_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   take,
  input  wire logic [7:0]             payload_byte,
  input  wire logic                   packet_first,
  input  wire logic                   packet_last,
  input  wire logic [32:0]            packet_pts,
  input  wire logic                   packet_pts_valid,
  input  wire logic [32:0]            packet_dts,
  input  wire logic                   packet_dts_valid,
  output mpts_pkg::ev_t               ev
);

  logic [23:0] recent;
  logic [23:0] recent_next;
  mpts_pkg::hdr_mode_t mode;
  mpts_pkg::hdr_mode_t mode_next;
  logic [2:0]  count;
  logic [2:0]  count_next;
  logic [31:0] capture;
  logic [31:0] capture_next;

  always_comb begin
    logic [23:0] r;
    mpts_pkg::hdr_mode_t m;
    logic [2:0]  c;
    logic [31:0] cap;
    r = recent;
    m = mode;
    c = count;
    cap = capture;
    if (packet_first) begin
      r = 24'hFFFFFF;
      m = mpts_pkg::HDR_NONE;
      c = 3'd0;
      cap = 32'd0;
    end
    ev = '0;
    ev.first = packet_first;
    ev.last = packet_last;
    ev.pts = packet_pts;
    ev.pts_valid = packet_pts_valid;
    ev.dts = packet_dts;
    ev.dts_valid = packet_dts_valid;
    ev.kind = mpts_pkg::EV_NONE;
    if (m != mpts_pkg::HDR_NONE) begin
      cap = {cap[23:0], payload_byte};
      c = c + 3'd1;
      if (m == mpts_pkg::HDR_SEQ && c >= 3'd4) begin
        m = mpts_pkg::HDR_NONE;
        ev.kind = mpts_pkg::EV_SEQ;
      end else if (m == mpts_pkg::HDR_PIC && c >= 3'd2) begin
        m = mpts_pkg::HDR_NONE;
        ev.kind = mpts_pkg::EV_PIC;
      end
    end
    ev.capture = cap;
    ev.ptype = payload_byte[5:3];
    if (r == 24'h000001 && (payload_byte == 8'hB3 || payload_byte == 8'h00)) begin
      m = (payload_byte == 8'hB3) ? mpts_pkg::HDR_SEQ : mpts_pkg::HDR_PIC;
      c = 3'd0;
      cap = 32'd0;
    end
    r = {r[15:0], payload_byte};
    if (packet_last) begin
      r = 24'hFFFFFF;
      m = mpts_pkg::HDR_NONE;
      c = 3'd0;
      cap = 32'd0;
    end
    recent_next = r;
    mode_next = m;
    count_next = c;
    capture_next = cap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent <= 24'hFFFFFF;
      mode <= mpts_pkg::HDR_NONE;
      count <= 3'd0;
      capture <= 32'd0;
    end else if (take) begin
      recent <= recent_next;
      mode <= mode_next;
      count <= count_next;
      capture <= capture_next;
    end
  end

endmodule
`default_nettype wire

>>> src/mpts_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpts_queue: event word queue between parser and timestamp engine
// A small register FIFO with full and empty flags.
// ----------------------------------------------------------------------------
module mpts_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  mpts_pkg::ev_t      push_word,
  output logic               full,
  input  wire logic          pop,
  output mpts_pkg::ev_t      pop_word,
  output logic               empty
);

  mpts_pkg::ev_t mem [mpts_pkg::QDepth];
  logic [mpts_pkg::QPtrBits-1:0] wptr;
  logic [mpts_pkg::QPtrBits-1:0] rptr;
  logic [mpts_pkg::QPtrBits:0]   fill;

  assign full = (fill == (mpts_pkg::QPtrBits+1)'(mpts_pkg::QDepth));
  assign empty = (fill == '0);
  assign pop_word = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= rptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/mpts_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpts_back: timestamp engine and result register
// Applies packet timestamps, extrapolates DTS/PTS for pictures, decodes
// sequence headers and holds one result word for the output channel.
// ----------------------------------------------------------------------------
module mpts_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          ev_avail,
  input  mpts_pkg::ev_t      ev,
  output logic               ev_take,
  output logic               valid,
  input  wire logic          stall,
  output logic               result_kind,
  output logic [2:0]         picture_type,
  output logic [32:0]        picture_pts,
  output logic               picture_pts_ok,
  output logic [32:0]        picture_dts,
  output logic               picture_dts_ok,
  output logic [11:0]        frame_width,
  output logic [11:0]        frame_height,
  output logic [3:0]         aspect_code,
  output logic [3:0]         rate_code,
  output logic [11:0]        frame_duration
);

  localparam int W = mpts_pkg::TsBits;

  logic [W-1:0] cur_pts, cur_pts_next;
  logic         cur_pts_v, cur_pts_v_next;
  logic [W-1:0] cur_dts, cur_dts_next;
  logic         cur_dts_v, cur_dts_v_next;
  logic [W-1:0] prev_dts, prev_dts_next;
  logic         prev_dts_v, prev_dts_v_next;
  logic [W-1:0] offset, offset_next;
  logic [11:0]  dur, dur_next;
  logic         pics, pics_next;
  logic         emit;
  logic         out_free;

  function automatic logic t_ok(input logic [2:0] t);
    return (t >= mpts_pkg::PicI) && (t <= mpts_pkg::PicD);
  endfunction

  assign out_free = !valid || !stall;
  assign ev_take = ev_avail && out_free;

  always_comb begin
    logic [W-1:0] d;
    logic [2:0]   t;
    cur_pts_next = cur_pts;
    cur_pts_v_next = cur_pts_v;
    cur_dts_next = cur_dts;
    cur_dts_v_next = cur_dts_v;
    prev_dts_next = prev_dts;
    prev_dts_v_next = prev_dts_v;
    offset_next = offset;
    dur_next = dur;
    pics_next = pics;
    emit = 1'b0;
    d = W'(dur);
    t = ev.ptype;
    if (ev.first) begin
      cur_pts_v_next = ev.pts_valid;
      cur_pts_next = ev.pts_valid ? ev.pts : '0;
      cur_dts_v_next = ev.dts_valid;
      cur_dts_next = ev.dts_valid ? ev.dts : '0;
      pics_next = 1'b0;
    end
    if (ev.kind == mpts_pkg::EV_SEQ) begin
      dur_next = mpts_pkg::rate_ticks(ev.capture[3:0]);
      emit = 1'b1;
    end else if (ev.kind == mpts_pkg::EV_PIC && dur != 12'd0) begin
      emit = 1'b1;
      if (pics_next) begin
        cur_pts_v_next = 1'b0;
        if (cur_dts_v_next) begin
          cur_dts_next = cur_dts_next + d;
        end
      end
      if (t < mpts_pkg::PicB && cur_dts_v_next && cur_pts_v_next) begin
        offset_next = cur_pts_next - cur_dts_next;
        prev_dts_next = cur_dts_next;
        prev_dts_v_next = 1'b1;
      end else begin
        if (!cur_dts_v_next) begin
          cur_dts_v_next = prev_dts_v;
          cur_dts_next = prev_dts_v ? prev_dts + d : '0;
          prev_dts_next = cur_dts_next;
          prev_dts_v_next = cur_dts_v_next;
        end
        if (t == mpts_pkg::PicB && !cur_pts_v_next) begin
          cur_pts_next = cur_dts_next;
          cur_pts_v_next = cur_dts_v_next;
        end
        if (t < mpts_pkg::PicB && !cur_pts_v_next) begin
          cur_pts_v_next = cur_dts_v_next;
          cur_pts_next = cur_dts_v_next ? cur_dts_next + offset : '0;
        end
      end
      pics_next = 1'b1;
    end
    if (ev.last) begin
      pics_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_pts <= '0;
      cur_pts_v <= 1'b0;
      cur_dts <= '0;
      cur_dts_v <= 1'b0;
      prev_dts <= '0;
      prev_dts_v <= 1'b0;
      offset <= '0;
      dur <= 12'd0;
      pics <= 1'b0;
      valid <= 1'b0;
    end else begin
      if (ev_take) begin
        cur_pts <= cur_pts_next;
        cur_pts_v <= cur_pts_v_next;
        cur_dts <= cur_dts_next;
        cur_dts_v <= cur_dts_v_next;
        prev_dts <= prev_dts_next;
        prev_dts_v <= prev_dts_v_next;
        offset <= offset_next;
        dur <= dur_next;
        pics <= pics_next;
      end
      if (out_free) begin
        valid <= ev_take && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_take && emit) begin
      result_kind <= 1'b0;
      picture_type <= 3'd0;
      picture_pts <= '0;
      picture_pts_ok <= 1'b0;
      picture_dts <= '0;
      picture_dts_ok <= 1'b0;
      frame_width <= 12'd0;
      frame_height <= 12'd0;
      aspect_code <= 4'd0;
      rate_code <= 4'd0;
      frame_duration <= 12'd0;
      if (ev.kind == mpts_pkg::EV_SEQ) begin
        result_kind <= 1'b1;
        frame_width <= ev.capture[31:20];
        frame_height <= ev.capture[19:8];
        aspect_code <= ev.capture[7:4];
        rate_code <= ev.capture[3:0];
        frame_duration <= dur_next;
      end else begin
        picture_type <= (t_ok(ev.ptype)) ? ev.ptype : 3'd0;
        picture_pts <= cur_pts_v_next ? 33'(cur_pts_next) : 33'd0;
        picture_pts_ok <= cur_pts_v_next;
        picture_dts <= cur_dts_v_next ? 33'(cur_dts_next) : 33'd0;
        picture_dts_ok <= cur_dts_v_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/mpeg2_video_picture_timestamper_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpeg2_video_picture_timestamper_core: MPEG-2 picture timestamper
// Parses video elementary stream bytes and reports sequence headers and
// pictures with their presentation and decoding timestamps.
// ----------------------------------------------------------------------------
// The block takes one payload byte per clock. A front parser searches for
// start codes inside each packet and captures sequence and picture headers;
// its event words pass through a four-word queue to a timestamp engine that
// keeps the DTS/PTS state and loads one output register. An input word is
// accepted whenever the queue has room, so the sustained rate is one byte
// per cycle as long as results are taken; a result is registered by the
// engine once its header's last byte has passed the queue. A stalled
// output fills the queue and then raises the input stall. Timestamps wrap
// modulo 2^33. Every byte goes through the queue because packet boundaries
// and timestamps must reach the engine in order with the headers.
module mpeg2_video_picture_timestamper_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   payload_byte,
  input  wire logic         packet_first,
  input  wire logic         packet_last,
  input  wire logic [32:0]  packet_pts,
  input  wire logic         packet_pts_valid,
  input  wire logic [32:0]  packet_dts,
  input  wire logic         packet_dts_valid,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic              result_kind,
  output logic [2:0]        picture_type,
  output logic [32:0]       picture_pts,
  output logic              picture_pts_ok,
  output logic [32:0]       picture_dts,
  output logic              picture_dts_ok,
  output logic [11:0]       frame_width,
  output logic [11:0]       frame_height,
  output logic [3:0]        aspect_code,
  output logic [3:0]        rate_code,
  output logic [11:0]       frame_duration
);

  mpts_pkg::ev_t front_word;
  mpts_pkg::ev_t back_word;
  logic q_full;
  logic q_empty;
  logic take;
  logic back_take;

  // A byte is taken whenever the queue can hold its event word.
  assign in_stall = q_full;
  assign take = in_valid && !q_full;

  mpts_front u_front (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .payload_byte     (payload_byte),
    .packet_first     (packet_first),
    .packet_last      (packet_last),
    .packet_pts       (packet_pts),
    .packet_pts_valid (packet_pts_valid),
    .packet_dts       (packet_dts),
    .packet_dts_valid (packet_dts_valid),
    .ev               (front_word)
  );

  mpts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_word (front_word),
    .full      (q_full),
    .pop       (back_take),
    .pop_word  (back_word),
    .empty     (q_empty)
  );

  mpts_back u_back (
    .clk            (clk),
    .rst            (rst),
    .ev_avail       (!q_empty),
    .ev             (back_word),
    .ev_take        (back_take),
    .valid          (out_valid),
    .stall          (out_stall),
    .result_kind    (result_kind),
    .picture_type   (picture_type),
    .picture_pts    (picture_pts),
    .picture_pts_ok (picture_pts_ok),
    .picture_dts    (picture_dts),
    .picture_dts_ok (picture_dts_ok),
    .frame_width    (frame_width),
    .frame_height   (frame_height),
    .aspect_code    (aspect_code),
    .rate_code      (rate_code),
    .frame_duration (frame_duration)
  );

`ifndef ASSERT_OFF
  // The engine never draws from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    back_take |-> !q_empty) else $error("event drawn from empty queue");

  // A held result does not change while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(picture_dts)
      && $stable(result_kind))) else $error("stalled result changed");

  // A sequence result always carries the duration that matches its rate code.
  a_dur: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind) |-> (frame_duration == mpts_pkg::rate_ticks(rate_code)))
    else $error("duration does not match rate code");
`endif

endmodule
`default_nettype wire
